// ----- src/nce_pkg.sv -----
// ============================================================================
// nce_pkg: shared types and constants for the neighbor contrast weights
// Widths, configuration codes, exp table builder and color distance helper.
// ============================================================================
package nce_pkg;

    localparam int MAX_WIDTH       = 2048;
    localparam int ADDR_W          = $clog2(MAX_WIDTH);
    localparam int COL_CNT_W       = ADDR_W + 1;
    localparam int EXP_TABLE_DEPTH = 1024;
    localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);

    localparam int CHAN_W      = 8;
    localparam int CHANNELS    = 3;
    localparam int PIX_W       = CHAN_W * CHANNELS;
    localparam int D2_W        = 18;
    localparam int GEOM_W      = 12;
    localparam int ROW_W       = 12;
    localparam int BETA_W      = 24;
    localparam int GAIN_W      = 8;
    localparam int EXP_W       = 16;
    localparam int WEIGHT_W    = 16;
    localparam int SUM_W       = 42;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;

    localparam int PROD_W      = BETA_W + D2_W;
    localparam int BETA_SHIFT  = 18;
    localparam int SCALE_Q_W   = 17;
    localparam int GE_W        = GAIN_W + EXP_W;
    localparam int SCALED_W    = GE_W + SCALE_Q_W;
    localparam int SCALE_SHIFT = 24;

    localparam int OUT_FIELDS_W = 4 * WEIGHT_W + SUM_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [SCALE_Q_W-1:0] INV_SQRT2_Q16 = SCALE_Q_W'(46341);
    localparam logic [SCALE_Q_W-1:0] UNIT_Q16      = SCALE_Q_W'(65536);
    localparam logic [31:0]          EXP_STEP_Q32  = 32'd4228380000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH     = 2'd0,
        CFG_IMAGE_HEIGHT    = 2'd1,
        CFG_BETA_SCALE      = 2'd2,
        CFG_SMOOTHNESS_GAIN = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        SLOT_LEFT    = 2'd0,
        SLOT_UPLEFT  = 2'd1,
        SLOT_UP      = 2'd2,
        SLOT_UPRIGHT = 2'd3
    } t_slot;

    typedef struct packed {
        logic            valid;
        logic            used;
        logic            diag;
        t_slot           slot;
        logic [D2_W-1:0] d2;
    } t_weight_req;

    typedef struct packed {
        logic                valid;
        t_slot               slot;
        logic [WEIGHT_W-1:0] weight;
    } t_weight_rsp;

    typedef logic [EXP_W-1:0] t_exp_table [EXP_TABLE_DEPTH];

    // exp(-i/64) in Q0.16, built by repeated multiplication by exp(-1/64) in Q0.32
    function automatic t_exp_table f_build_exp_table();
        t_exp_table  tbl;
        logic [64:0] v;
        logic [64:0] e;
        v = 65'(1) << 32;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            e = (v + 65'd32768) >> 16;
            tbl[i] = (e > 65'd65535) ? {EXP_W{1'b1}} : e[EXP_W-1:0];
            v = (v * {33'd0, EXP_STEP_Q32} + (65'd1 << 31)) >> 32;
        end
        return tbl;
    endfunction

    // squared color distance, summed over the three channels
    function automatic logic [D2_W-1:0] f_dist2(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
        logic [D2_W-1:0]        acc;
        logic signed [CHAN_W:0] d;
        logic signed [17:0]     sq;
        acc = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            d   = $signed({1'b0, a[c*CHAN_W +: CHAN_W]})
                - $signed({1'b0, b[c*CHAN_W +: CHAN_W]});
            sq  = d * d;
            acc = acc + D2_W'($unsigned(sq));
        end
        return acc;
    endfunction

endpackage

// ----- src/neighbour_contrast_edge_weights.sv -----
// ============================================================================
// neighbour_contrast_edge_weights: 8-connected smoothness weights, four per pixel
// Line store, neighbor sequencer, shared weight pipeline and result register.
// ============================================================================
// Usage:
//   Pixels enter on the s_axis channel in raster order, one transaction per
//   pixel (red, green, blue). Each pixel gives exactly one transaction on the
//   m_axis channel with the four Q8.8 weights to its left, upper-left, upper
//   and upper-right neighbors and the running color-distance sum of the
//   frame; tlast marks the frame's last pixel, after which the sum restarts.
//   Geometry, beta and gain are to be written on the i_cfg_* port while idle (unenforced).
// Sequence:
//   A pixel is accepted in S_IDLE, which also fetches its upper and
//   upper-right neighbors from the line store; S_FEED passes the four
//   neighbors one by one into the shared five-stage weight pipeline,
//   S_DRAIN waits for the pipeline to drain and captures the weights,
//   and S_EMIT loads the output register. A new pixel is accepted only
//   after that load.
// Reset (i_rst_n low, synchronous): counters, sum and held neighbors clear,
//   registers return to 640 x 480, beta 0, gain 50. The line store is not
//   cleared; the first row never uses what it reads from it.
// Stall: a finished result waits in the output register; the block finishes
//   the next pixel and holds it until the register frees.
module neighbour_contrast_edge_weights
    import nce_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // pixel input
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [PIX_W-1:0]       s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
    // weight output
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // left_weight[15:0], upleft_weight[31:16], up_weight[47:32],
    // upright_weight[63:48], contrast_sum[105:64], zero pad[111:106]
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                   m_axis_tlast   // frame_end
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FEED  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    // configuration
    logic [GEOM_W-1:0]    r_image_width;
    logic [GEOM_W-1:0]    r_image_height;
    logic [BETA_W-1:0]    r_beta_scale;
    logic [GAIN_W-1:0]    r_gain;

    // sequencer and frame state
    t_state               r_state;
    t_state               n_state;
    t_slot                r_slot;
    logic [ADDR_W-1:0]    r_col;
    logic [ROW_W-1:0]     r_row;
    logic [SUM_W-1:0]     r_total;
    logic [PIX_W-1:0]     r_cur;
    logic [PIX_W-1:0]     r_left_pixel;
    logic [PIX_W-1:0]     r_upleft_pixel;
    logic                 r_first_col;
    logic                 r_first_row;
    logic                 r_last_col;
    logic                 r_frame_end;
    t_weight_req          r_req;

    // collected weights
    logic [WEIGHT_W-1:0]  r_w_left;
    logic [WEIGHT_W-1:0]  r_w_upleft;
    logic [WEIGHT_W-1:0]  r_w_up;
    logic [WEIGHT_W-1:0]  r_w_upright;

    // output register
    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                 r_out_last;

    logic                 w_accept;
    logic                 w_out_load;
    logic [COL_CNT_W-1:0] w_width_eff;
    logic [GEOM_W-1:0]    w_height_eff;
    logic                 w_last_col;
    logic                 w_last_row;
    logic [PIX_W-1:0]     w_up;
    logic [PIX_W-1:0]     w_upright;
    logic [PIX_W-1:0]     w_neighbor;
    logic                 w_used;
    logic [SUM_W:0]       w_sum;
    t_weight_rsp          w_rsp;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_load    = (r_state == S_EMIT) && (!r_out_valid || m_axis_tready);

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= GEOM_W'(640);
            r_image_height <= GEOM_W'(480);
            r_beta_scale   <= '0;
            r_gain         <= GAIN_W'(50);
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_IMAGE_WIDTH:     r_image_width  <= i_cfg_data[GEOM_W-1:0];
                CFG_IMAGE_HEIGHT:    r_image_height <= i_cfg_data[GEOM_W-1:0];
                CFG_BETA_SCALE:      r_beta_scale   <= i_cfg_data[BETA_W-1:0];
                CFG_SMOOTHNESS_GAIN: r_gain         <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // -------------------------------------------------------------- geometry
    // A zero width or height counts as one; width clamps to the line store.
    always_comb begin
        if (r_image_width == '0) begin
            w_width_eff = COL_CNT_W'(1);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w_width_eff = COL_CNT_W'(MAX_WIDTH);
        end else begin
            w_width_eff = COL_CNT_W'(r_image_width);
        end
        w_height_eff = (r_image_height == '0) ? GEOM_W'(1) : r_image_height;
    end

    // "at or past" also ends a row or frame shrunk mid-way
    assign w_last_col = (COL_CNT_W'(r_col) + COL_CNT_W'(1)) >= w_width_eff;
    assign w_last_row = ((ROW_W+1)'(r_row) + (ROW_W+1)'(1)) >= (ROW_W+1)'(w_height_eff);

    // ------------------------------------------------------------ line store
    // Read the upper and upper-right neighbors and write the new pixel in
    // the same cycle; the read returns the previous row's value.
    nce_line_store u_line_store (
        .i_clk     (i_clk),
        .i_we      (w_accept),
        .i_waddr   (r_col),
        .i_wdata   (s_axis_tdata),
        .i_re      (w_accept),
        .i_raddr_a (r_col),
        .i_raddr_b (ADDR_W'(COL_CNT_W'(r_col) + COL_CNT_W'(1))),
        .o_rdata_a (w_up),
        .o_rdata_b (w_upright)
    );

    // --------------------------------------------------------- neighbor feed
    always_comb begin
        case (r_slot)
            SLOT_LEFT: begin
                w_neighbor = r_left_pixel;
                w_used     = !r_first_col;
            end
            SLOT_UPLEFT: begin
                w_neighbor = r_upleft_pixel;
                w_used     = !r_first_row && !r_first_col;
            end
            SLOT_UP: begin
                w_neighbor = w_up;
                w_used     = !r_first_row;
            end
            SLOT_UPRIGHT: begin
                w_neighbor = w_upright;
                w_used     = !r_first_row && !r_last_col;
            end
            default: begin
                w_neighbor = w_up;
                w_used     = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req <= '0;
        end else if (r_state == S_FEED) begin
            r_req.valid <= 1'b1;
            r_req.used  <= w_used;
            r_req.diag  <= (r_slot == SLOT_UPLEFT) || (r_slot == SLOT_UPRIGHT);
            r_req.slot  <= r_slot;
            r_req.d2    <= f_dist2(r_cur, w_neighbor);
        end else begin
            r_req.valid <= 1'b0;
        end
    end

    nce_weight_unit u_weight_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beta  (r_beta_scale),
        .i_gain  (r_gain),
        .i_req   (r_req),
        .o_rsp   (w_rsp)
    );

    // ------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_FEED;
            S_FEED:  if (r_slot == SLOT_UPRIGHT) n_state = S_DRAIN;
            S_DRAIN: if (w_rsp.valid && w_rsp.slot == SLOT_UPRIGHT) n_state = S_EMIT;
            S_EMIT:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_slot         <= SLOT_LEFT;
            r_col          <= '0;
            r_row          <= '0;
            r_left_pixel   <= '0;
            r_upleft_pixel <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_slot <= SLOT_LEFT;
                // advance the raster position
                if (w_last_col) begin
                    r_col <= '0;
                    r_row <= w_last_row ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + ADDR_W'(1);
                end
            end else if (r_state == S_FEED) begin
                r_slot <= t_slot'(r_slot + 2'd1);
                if (r_slot == SLOT_UPRIGHT) begin
                    // this pixel becomes the next one's left neighbor
                    r_left_pixel   <= r_cur;
                    r_upleft_pixel <= w_up;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cur       <= s_axis_tdata;
            r_first_col <= (r_col == '0);
            r_first_row <= (r_row == '0);
            r_last_col  <= w_last_col;
            r_frame_end <= w_last_col && w_last_row;
        end
        if (w_rsp.valid) begin
            case (w_rsp.slot)
                SLOT_LEFT:    r_w_left    <= w_rsp.weight;
                SLOT_UPLEFT:  r_w_upleft  <= w_rsp.weight;
                SLOT_UP:      r_w_up      <= w_rsp.weight;
                SLOT_UPRIGHT: r_w_upright <= w_rsp.weight;
                default: ;
            endcase
        end
    end

    // ----------------------------------------------------------- contrast sum
    assign w_sum = {1'b0, r_total} + (SUM_W+1)'(r_req.d2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (w_out_load && r_frame_end) begin
            r_total <= '0;
        end else if (r_req.valid && r_req.used) begin
            // saturate on carry out
            r_total <= w_sum[SUM_W] ? {SUM_W{1'b1}} : w_sum[SUM_W-1:0];
        end
    end

    // ------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= OUT_DATA_W'({r_total, r_w_upright, r_w_up, r_w_upleft, r_w_left});
            r_out_last <= r_frame_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------ assertions
    a_rsp_only_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.valid |-> (r_state == S_DRAIN))
        else $error("weight response outside drain");

    a_accept_starts_feed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_FEED && r_slot == SLOT_LEFT))
        else $error("accepted pixel did not start the neighbor feed");

    a_sum_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_EMIT) |=> (r_total >= $past(r_total)))
        else $error("contrast sum decreased within a frame");

    a_sum_clears_at_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_frame_end) |=> (r_total == '0))
        else $error("contrast sum not cleared after frame end");

endmodule

// ----- src/nce_line_store.sv -----
// ============================================================================
// nce_line_store: previous-row pixel memory
// One write port and two registered read ports, read-before-write.
// ============================================================================
module nce_line_store
    import nce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [PIX_W-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [PIX_W-1:0]  o_rdata_a,
    output logic [PIX_W-1:0]  o_rdata_b
);

    logic [PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_rdata_a;
    logic [PIX_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- src/nce_weight_unit.sv -----
// ============================================================================
// nce_weight_unit: shared five-stage weight pipeline
// gain * exp(-beta * d2), optionally times 1/sqrt2, rounded to Q8.8.
// ============================================================================
module nce_weight_unit
    import nce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BETA_W-1:0] i_beta,
    input  logic [GAIN_W-1:0] i_gain,
    input  t_weight_req       i_req,
    output t_weight_rsp       o_rsp
);

    localparam t_exp_table EXP_ROM = f_build_exp_table();

    logic [4:0]            r_valid;
    logic [PROD_W-1:0]     r_s1_prod;
    logic                  r_s1_used;
    logic [EXP_W-1:0]      r_s2_e;
    logic [GE_W-1:0]       r_s3_ge;
    logic [SCALED_W-1:0]   r_s4_scaled;
    logic [WEIGHT_W-1:0]   r_s5_weight;
    logic [2:0]            r_diag;
    t_slot                 r_slot [5];

    logic                  w_out_of_range;
    logic [EXP_IDX_W-1:0]  w_idx;
    logic [SCALED_W:0]     w_rounded;

    assign w_out_of_range = |r_s1_prod[PROD_W-1:BETA_SHIFT+EXP_IDX_W];
    assign w_idx          = r_s1_prod[BETA_SHIFT+EXP_IDX_W-1:BETA_SHIFT];
    assign w_rounded      = {1'b0, r_s4_scaled} + ((SCALED_W+1)'(1) << (SCALE_SHIFT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[3:0], i_req.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_prod   <= PROD_W'(i_beta) * PROD_W'(i_req.d2);
        r_s1_used   <= i_req.used;
        // drop to zero past the end of the table or for a missing neighbor
        r_s2_e      <= (!r_s1_used || w_out_of_range) ? '0 : EXP_ROM[w_idx];
        r_s3_ge     <= GE_W'(i_gain) * GE_W'(r_s2_e);
        r_s4_scaled <= SCALED_W'(r_s3_ge) * SCALED_W'(r_diag[2] ? INV_SQRT2_Q16 : UNIT_Q16);
        r_s5_weight <= w_rounded[SCALE_SHIFT +: WEIGHT_W];
        r_diag      <= {r_diag[1:0], i_req.diag};
        r_slot[0]   <= i_req.slot;
        for (int s = 1; s < 5; s++) begin
            r_slot[s] <= r_slot[s-1];
        end
    end

    assign o_rsp.valid  = r_valid[4];
    assign o_rsp.slot   = r_slot[4];
    assign o_rsp.weight = r_s5_weight;

endmodule

// ----- tb/sv/neighbour_contrast_edge_weights_tb.sv -----
// ============================================================================
// neighbour_contrast_edge_weights_tb: self-checking bench for the edge weights
// Streams RGB frames through the block under many geometry, beta and gain
// settings, predicts every weight set in a scoreboard and checks each output
// transaction field by field, with random idling on both stream sides.
// ============================================================================
module neighbour_contrast_edge_weights_tb
    import nce_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Arithmetic constants of the weight path, kept independent of the RTL.
    localparam longint unsigned EXP_DECAY_Q32 = 64'd4228380000;  // exp(-1/64)
    localparam longint unsigned DIAG_Q16      = 64'd46341;       // 1/sqrt(2)
    localparam longint unsigned SUM_LIMIT     = (64'd1 << 42) - 64'd1;
    localparam int              ARG_SHIFT     = 18;              // Q.24 -> 1/64 steps
    localparam int              RANDOM_PIXELS = 1080;
    localparam int              SETTLE_CYCLES = 24;

    // Corner image: black, white, single- and two-channel extremes on a 3x3 grid.
    localparam logic [23:0] CORNER_PIX [9] = '{
        24'h000000, 24'hFFFFFF, 24'h000000,
        24'hFFFFFF, 24'h00FF00, 24'hFF00FF,
        24'hFF0000, 24'hFFFFFF, 24'h0000FF
    };

    typedef enum {PAT_NOISE, PAT_SMOOTH, PAT_EXTREME} t_pattern;

    // One output transaction as the block should present it.
    typedef struct packed {
        logic [WEIGHT_W-1:0] left_w;
        logic [WEIGHT_W-1:0] upleft_w;
        logic [WEIGHT_W-1:0] up_w;
        logic [WEIGHT_W-1:0] upright_w;
        logic [SUM_W-1:0]    run_sum;
        logic                frame_end;
    } t_weight_set;

    // ------------------------------------------------------------------------
    // Scoreboard: carries its own copy of the line store, neighbors, counters
    // and registers, computes the weight set of every accepted pixel and
    // compares it against the output stream in order.
    // ------------------------------------------------------------------------
    class nce_weight_scoreboard;
        logic [EXP_W-1:0] decay_q16 [EXP_TABLE_DEPTH];
        int unsigned      width_reg, height_reg, beta_reg, gain_reg;
        logic [PIX_W-1:0] line_mem [MAX_WIDTH];
        logic [PIX_W-1:0] left_pix, upleft_pix;
        int unsigned      col, row;
        longint unsigned  dist_total;
        t_weight_set      weights_due[$];
        int               errors;
        int               results_seen, frames_seen, pixels_seen;

        function new();
            longint unsigned v, e;
            v = 64'd1 << 32;
            for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
                e = (v + 64'd32768) >> 16;
                decay_q16[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
                v = (v * EXP_DECAY_Q32 + (64'd1 << 31)) >> 32;
            end
            foreach (line_mem[i]) line_mem[i] = '0;
            width_reg  = 640;
            height_reg = 480;
            beta_reg   = 0;
            gain_reg   = 50;
            left_pix   = '0;
            upleft_pix = '0;
            col        = 0;
            row        = 0;
            dist_total = 0;
        endfunction

        function void set_register(input t_cfg_index idx, input int unsigned value);
            case (idx)
                CFG_IMAGE_WIDTH:     width_reg  = value & 32'hFFF;
                CFG_IMAGE_HEIGHT:    height_reg = value & 32'hFFF;
                CFG_BETA_SCALE:      beta_reg   = value & 32'hFF_FFFF;
                CFG_SMOOTHNESS_GAIN: gain_reg   = value & 32'hFF;
                default: ;
            endcase
        endfunction

        // zero reads as one, anything past the line store clamps to it
        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function int unsigned pixels_left_in_frame();
            int unsigned w, h, n;
            w = eff_width();
            h = eff_height();
            n = (col + 1 >= w) ? 1 : w - col;
            if (row + 1 < h) n += (h - 1 - row) * w;
            return n;
        endfunction

        function int unsigned pending();
            return weights_due.size();
        endfunction

        function int unsigned colour_dist(input logic [PIX_W-1:0] a,
                                          input logic [PIX_W-1:0] b);
            int unsigned acc;
            int          d;
            acc = 0;
            for (int c = 0; c < CHANNELS; c++) begin
                d   = int'(a[c*CHAN_W +: CHAN_W]) - int'(b[c*CHAN_W +: CHAN_W]);
                acc += d * d;
            end
            return acc;
        endfunction

        // exp(-beta*d2) in Q0.16, zero once the argument runs off the table
        function longint unsigned decay(input int unsigned d2);
            longint unsigned arg;
            arg = beta_reg;
            arg = (arg * d2) >> ARG_SHIFT;
            return (arg >= EXP_TABLE_DEPTH) ? 0 : decay_q16[arg];
        endfunction

        function logic [WEIGHT_W-1:0] straight_weight(input int unsigned d2);
            longint unsigned g;
            g = gain_reg;
            return WEIGHT_W'((g * decay(d2) + 64'd128) >> 8);
        endfunction

        function logic [WEIGHT_W-1:0] diagonal_weight(input int unsigned d2);
            longint unsigned g;
            g = gain_reg;
            return WEIGHT_W'((g * decay(d2) * DIAG_Q16 + (64'd1 << 23)) >> 24);
        endfunction

        function void add_distance(input int unsigned d2);
            dist_total += d2;
            if (dist_total > SUM_LIMIT) dist_total = SUM_LIMIT;
        endfunction

        // Work out the weight set of one accepted pixel and advance the state.
        function void note_pixel(input logic [PIX_W-1:0] pix);
            int unsigned      w, h, d;
            logic             last_col, last_row;
            logic [PIX_W-1:0] up_pix, upright_pix;
            t_weight_set      ws;
            w        = eff_width();
            h        = eff_height();
            last_col = (col + 1 >= w);
            last_row = (row + 1 >= h);
            up_pix      = line_mem[col % MAX_WIDTH];
            upright_pix = last_col ? '0 : line_mem[(col + 1) % MAX_WIDTH];
            ws = '0;
            if (col > 0) begin
                d = colour_dist(pix, left_pix);
                ws.left_w = straight_weight(d);
                add_distance(d);
            end
            if (row > 0 && col > 0) begin
                d = colour_dist(pix, upleft_pix);
                ws.upleft_w = diagonal_weight(d);
                add_distance(d);
            end
            if (row > 0) begin
                d = colour_dist(pix, up_pix);
                ws.up_w = straight_weight(d);
                add_distance(d);
            end
            if (row > 0 && !last_col) begin
                d = colour_dist(pix, upright_pix);
                ws.upright_w = diagonal_weight(d);
                add_distance(d);
            end
            ws.run_sum   = dist_total[SUM_W-1:0];
            ws.frame_end = last_col && last_row;
            weights_due = {weights_due, ws};

            line_mem[col % MAX_WIDTH] = pix;
            upleft_pix = up_pix;
            left_pix   = pix;
            if (last_col) begin
                col = 0;
                if (last_row) begin
                    row        = 0;
                    dist_total = 0;
                end else begin
                    row = row + 1;
                end
            end else begin
                col = col + 1;
            end
            pixels_seen++;
        endfunction

        function void flag(input string what, input longint unsigned want,
                           input longint unsigned got);
            errors++;
            $display("%0t ns: %s on result %0d: expected %0d actual %0d",
                     $time, what, results_seen, want, got);
        endfunction

        function void compare_field(input string name, input longint unsigned want,
                                    input longint unsigned got);
            if (want != got) flag({name, " mismatch"}, want, got);
        endfunction

        // Check one output transaction against the oldest pending weight set.
        function void check_result(input logic [OUT_DATA_W-1:0] data, input logic last);
            t_weight_set ws;
            results_seen++;
            if (last === 1'b1) frames_seen++;
            if (weights_due.size() == 0) begin
                flag("result with no pixel pending", 0, 1);
                return;
            end
            ws = weights_due.pop_front();
            compare_field("left_weight",    ws.left_w,    data[15:0]);
            compare_field("upleft_weight",  ws.upleft_w,  data[31:16]);
            compare_field("up_weight",      ws.up_w,      data[47:32]);
            compare_field("upright_weight", ws.upright_w, data[63:48]);
            compare_field("contrast_sum",   ws.run_sum,   data[105:64]);
            compare_field("frame_end",      ws.frame_end, last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [PIX_W-1:0]       s_axis_tdata;       // red[7:0], green[15:8], blue[23:16]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // left_weight[15:0], upleft_weight[31:16], up_weight[47:32],
    // upright_weight[63:48], contrast_sum[105:64], zero pad[111:106]
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tlast;       // frame_end

    neighbour_contrast_edge_weights DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    nce_weight_scoreboard sb;
    logic [PIX_W-1:0]     last_colour;
    bit                   tx_calm;          // sender sends back to back
    bit                   rx_calm;          // receiver never stalls
    int                   register_writes;
    int                   geometry_changes;

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the stream hangs.
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Pixel content
    // ------------------------------------------------------------------------
    // Smooth runs keep d2 small so the exp table is hit across its range;
    // noise and saturated channels push the argument off the table.
    function automatic t_pattern pick_pattern();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5) return PAT_SMOOTH;
        if (r < 8) return PAT_NOISE;
        return PAT_EXTREME;
    endfunction

    function automatic logic [PIX_W-1:0] next_colour(input t_pattern pat);
        logic [PIX_W-1:0] c;
        int               v;
        c = last_colour;
        case (pat)
            PAT_NOISE: c = PIX_W'($urandom);
            PAT_SMOOTH: begin
                for (int k = 0; k < CHANNELS; k++) begin
                    v = int'(last_colour[k*CHAN_W +: CHAN_W]) + int'($urandom_range(0, 8)) - 4;
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                    c[k*CHAN_W +: CHAN_W] = v[7:0];
                end
            end
            PAT_EXTREME: begin
                for (int k = 0; k < CHANNELS; k++)
                    c[k*CHAN_W +: CHAN_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default: ;
        endcase
        last_colour = c;
        return c;
    endfunction

    function automatic int unsigned pick_beta();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 24'hFF_FFFF;
            2:       return $urandom_range(0, 24'h00_3FFF);
            3:       return $urandom_range(0, 24'h00_FFFF);
            4:       return $urandom_range(0, 24'h0F_FFFF);
            default: return $urandom & 32'hFF_FFFF;
        endcase
    endfunction

    function automatic int unsigned pick_gain();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Drivers. All of them start and end on a falling edge.
    // ------------------------------------------------------------------------
    // Offer one pixel after a random gap and hold it until the transaction.
    // Drop tvalid only when a gap is taken so a back-to-back stream never
    // sees a low/high pair in the same step.
    task automatic drive_pixel(input logic [PIX_W-1:0] pix);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_pixel(pix);
        @(negedge i_clk);
    endtask

    task automatic stream_pixels(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            drive_pixel(next_colour(pick_pattern()));
    endtask

    // Release the input and wait until every predicted result has come back;
    // the block is idle after that and registers may be written.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_register(input t_cfg_index idx, input int unsigned value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        sb.set_register(idx, value);
        register_writes++;
    endtask

    task automatic configure(input int unsigned w, input int unsigned h,
                             input int unsigned beta, input int unsigned gain);
        write_register(CFG_IMAGE_WIDTH, w);
        write_register(CFG_IMAGE_HEIGHT, h);
        write_register(CFG_BETA_SCALE, beta);
        write_register(CFG_SMOOTHNESS_GAIN, gain);
    endtask

    // ------------------------------------------------------------------------
    // Output side: stall at random before each result (never when rx_calm), then accept
    // the next transaction and hand it to the scoreboard.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned stall;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            sb.check_result(m_axis_tdata, m_axis_tlast);
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned w, h, frames, random_start;
        sb               = new();
        last_colour      = 24'h808080;
        tx_calm          = 1'b0;
        rx_calm          = 1'b0;
        register_writes  = 0;
        geometry_changes = 0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_IMAGE_WIDTH;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Corner image with beta zero and full gain: every neighbor that
        // exists gets the largest weight, first row/column and last column
        // give zeros, and the sum picks up the biggest distances.
        configure(3, 3, 0, 255);
        foreach (CORNER_PIX[i]) drive_pixel(CORNER_PIX[i]);
        drain_results();

        // Largest beta: equal pixels still give the top of the table, a one
        // step difference lands at index 63, early in the table.
        configure(2, 2, 24'hFF_FFFF, 50);
        drive_pixel(24'h123456);
        drive_pixel(24'h123456);
        drive_pixel(24'h123456);
        drive_pixel(24'h123457);
        drain_results();

        // Zero width and height read as one: every pixel is a whole frame,
        // with no neighbors and gain zero.
        configure(0, 0, 24'h000400, 0);
        stream_pixels(3);
        drain_results();

        // Tallest frame one pixel wide, then cut its height mid-frame so the
        // current row becomes the last one.
        configure(1, 4095, 24'h002000, 200);
        stream_pixels(6);
        drain_results();
        write_register(CFG_IMAGE_HEIGHT, 3);
        geometry_changes++;
        stream_pixels(sb.pixels_left_in_frame());
        drain_results();

        // Random frames under random settings. Whole frames only, so each
        // new setting starts on a fresh frame; some frames get their width
        // narrowed (never widened) and height, beta or gain changed part way through.
        random_start = sb.pixels_seen;
        while (sb.pixels_seen < random_start + RANDOM_PIXELS) begin
            case ($urandom_range(0, 9))
                0:       w = 0;
                1:       w = $urandom_range(25, 150);
                default: w = $urandom_range(1, 24);
            endcase
            h = (w > 24) ? $urandom_range(0, 2) : $urandom_range(0, 6);
            drain_results();
            configure(w, h, pick_beta(), pick_gain());
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            frames  = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                if ($urandom_range(0, 3) == 0 && sb.pixels_left_in_frame() > 1) begin
                    stream_pixels($urandom_range(1, sb.pixels_left_in_frame() - 1));
                    drain_results();
                    write_register(CFG_IMAGE_WIDTH, $urandom_range(1, sb.eff_width()));
                    if ($urandom_range(0, 1)) write_register(CFG_IMAGE_HEIGHT, $urandom_range(0, 8));
                    if ($urandom_range(0, 1)) write_register(CFG_BETA_SCALE, pick_beta());
                    if ($urandom_range(0, 1)) write_register(CFG_SMOOTHNESS_GAIN, pick_gain());
                    geometry_changes++;
                end
                stream_pixels(sb.pixels_left_in_frame());
            end
        end

        // Let the pipeline empty and watch for stray results.
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Streamed %0d pixels in %0d frames with %0d register writes (%0d mid-frame).",
                 sb.pixels_seen, sb.frames_seen, register_writes, geometry_changes);
        $display("Checked %0d weight sets; %0d field errors.", sb.results_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/nce_pkg.sv
src/nce_line_store.sv
src/nce_weight_unit.sv
src/neighbour_contrast_edge_weights.sv
tb/sv/neighbour_contrast_edge_weights_tb.sv
